>>> rtl/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

    // Fixed field widths on the stream ports
    localparam int VALUE_W     = 32;
    localparam int PLATE_W     = 4;
    localparam int FUNC_W      = 2;
    localparam int OCC_W       = 8;
    localparam int IN_TDATA_W  = 40;  // push_value, plate_index, zero pad
    localparam int OUT_TDATA_W = 40;  // out_value, occupancy
    localparam int IN_TUSER_W  = 2;   // func
    localparam int OUT_TUSER_W = 1;   // ok

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_POP_AT = 2'd2
    } t_func;

    // Source of the result registers
    typedef enum logic [1:0] {
        RES_HOLD,
        RES_FAIL,
        RES_PUSH,
        RES_READ
    } t_res_sel;

    // Memory read address source
    typedef enum logic [1:0] {
        RD_TOP,
        RD_SLOT,
        RD_NEXT1,
        RD_NEXT2
    } t_rd_sel;

    typedef struct packed {
        logic     accept;    // latch input payload
        logic     push_wr;   // store value on top, count up
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     shift_wr;  // move read word down to pointer, advance pointer
        logic     load_ptr;  // pointer to the removed slot
        logic     dec;       // count down
        t_res_sel res_sel;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic plate_top;   // named plate holds the top item
        logic plate_low;   // named plate lies below the top plate
        logic more0;       // an entry sits right above the pointer
        logic more1;       // an entry sits two above the pointer
    } t_status;

endpackage

>>> rtl/psp_ctrl.sv
`timescale 1ns / 1ps

module psp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  psp_pkg::t_func    i_func,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output psp_pkg::t_cmd     o_cmd,
    input  psp_pkg::t_status  i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_POP_CAP,
        S_SLOT_CAP,
        S_SHIFT,
        S_DONE
    } t_state;

    t_state         r_state, n_state;
    psp_pkg::t_func r_func;
    logic           r_out_valid;
    psp_pkg::t_cmd  w_cmd;

    // hold off the input side while reset is applied
    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

    always_comb begin
        n_state        = r_state;
        w_cmd          = '0;
        w_cmd.rd_sel   = psp_pkg::RD_TOP;
        w_cmd.res_sel  = psp_pkg::RES_HOLD;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_DONE;
                unique case (r_func)
                    psp_pkg::FUNC_PUSH: begin
                        if (!i_status.full) begin
                            w_cmd.push_wr = 1'b1;
                            w_cmd.res_sel = psp_pkg::RES_PUSH;
                        end else begin
                            w_cmd.res_sel = psp_pkg::RES_FAIL;
                        end
                    end
                    psp_pkg::FUNC_POP: begin
                        if (!i_status.empty) begin
                            w_cmd.rd_en  = 1'b1;
                            w_cmd.rd_sel = psp_pkg::RD_TOP;
                            w_cmd.dec    = 1'b1;
                            n_state      = S_POP_CAP;
                        end else begin
                            w_cmd.res_sel = psp_pkg::RES_FAIL;
                        end
                    end
                    psp_pkg::FUNC_POP_AT: begin
                        priority if (i_status.plate_top) begin
                            w_cmd.rd_en  = 1'b1;
                            w_cmd.rd_sel = psp_pkg::RD_TOP;
                            w_cmd.dec    = 1'b1;
                            n_state      = S_POP_CAP;
                        end else if (i_status.plate_low) begin
                            w_cmd.rd_en    = 1'b1;
                            w_cmd.rd_sel   = psp_pkg::RD_SLOT;
                            w_cmd.load_ptr = 1'b1;
                            n_state        = S_SLOT_CAP;
                        end else begin
                            w_cmd.res_sel = psp_pkg::RES_FAIL;
                        end
                    end
                    default: begin
                        w_cmd.res_sel = psp_pkg::RES_FAIL;
                    end
                endcase
            end
            S_POP_CAP: begin
                w_cmd.res_sel = psp_pkg::RES_READ;
                n_state       = S_DONE;
            end
            S_SLOT_CAP: begin
                w_cmd.res_sel = psp_pkg::RES_READ;
                if (i_status.more0) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = psp_pkg::RD_NEXT1;
                    n_state      = S_SHIFT;
                end else begin
                    w_cmd.dec = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_SHIFT: begin
                // write this word down while fetching the one after it
                w_cmd.shift_wr = 1'b1;
                if (i_status.more1) begin
                    w_cmd.rd_en  = 1'b1;
                    w_cmd.rd_sel = psp_pkg::RD_NEXT2;
                end else begin
                    w_cmd.dec = 1'b1;
                    n_state   = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_func      <= psp_pkg::FUNC_PUSH;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.accept) begin
                r_func <= i_func;
            end
            if (w_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/psp_dp.sv
`timescale 1ns / 1ps

module psp_dp #(
    parameter int PLATE_DEPTH = 8,
    parameter int NUM_PLATES  = 16,
    parameter int DATA_W      = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  psp_pkg::t_cmd                 i_cmd,
    output psp_pkg::t_status              o_status,
    input  logic [psp_pkg::VALUE_W-1:0]   i_push_value,
    input  logic [psp_pkg::PLATE_W-1:0]   i_plate_index,
    output logic [psp_pkg::VALUE_W-1:0]   o_out_value,
    output logic                          o_out_ok,
    output logic [psp_pkg::OCC_W-1:0]     o_occupancy
);

    localparam int CAP    = PLATE_DEPTH * NUM_PLATES;
    localparam int ADDR_W = $clog2(CAP);
    localparam int CNT_W  = $clog2(CAP + 1);
    localparam int PD_W   = $clog2(PLATE_DEPTH + 1);
    localparam int CMP_W  = ((CNT_W > psp_pkg::PLATE_W + PD_W) ?
                             CNT_W : psp_pkg::PLATE_W + PD_W) + 1;
    localparam int PTR_W  = CNT_W + 1;

    logic [DATA_W-1:0]               r_mem [CAP];
    logic [DATA_W-1:0]               r_rdata;
    logic [DATA_W-1:0]               r_val;
    logic [psp_pkg::PLATE_W-1:0]     r_plate;
    logic [CNT_W-1:0]                r_count;
    logic [ADDR_W-1:0]               r_ptr;
    logic [psp_pkg::VALUE_W-1:0]     r_res_value;
    logic                            r_res_ok;
    logic [psp_pkg::VALUE_W-1:0]     r_out_value;
    logic                            r_out_ok;
    logic [psp_pkg::OCC_W-1:0]       r_out_occ;

    logic [DATA_W+psp_pkg::VALUE_W-1:0] w_in_ext;
    logic [DATA_W+psp_pkg::VALUE_W-1:0] w_rd_ext;
    logic [CMP_W-1:0]                   w_plate_base;
    logic [CMP_W-1:0]                   w_plate_end;
    logic [CMP_W-1:0]                   w_cnt_x;
    logic [CMP_W-1:0]                   w_slot;
    logic [PTR_W-1:0]                   w_ptr_x;
    logic [PTR_W-1:0]                   w_cnt_p;
    logic [PTR_W-1:0]                   w_ptr_p1;
    logic [PTR_W-1:0]                   w_ptr_p2;
    logic [CNT_W-1:0]                   w_cnt_m1;
    logic [ADDR_W-1:0]                  w_raddr;
    logic                               w_we;
    logic [ADDR_W-1:0]                  w_waddr;
    logic [DATA_W-1:0]                  w_wdata;

    assign w_in_ext = {{DATA_W{1'b0}}, i_push_value};
    assign w_rd_ext = {{psp_pkg::VALUE_W{1'b0}}, r_rdata};

    // plate p spans entries [p*PLATE_DEPTH, (p+1)*PLATE_DEPTH)
    assign w_plate_base = CMP_W'(r_plate) * CMP_W'(PLATE_DEPTH);
    assign w_plate_end  = w_plate_base + CMP_W'(PLATE_DEPTH);
    assign w_slot       = w_plate_end - CMP_W'(1);
    assign w_cnt_x      = CMP_W'(r_count);

    assign w_ptr_x  = PTR_W'(r_ptr);
    assign w_cnt_p  = PTR_W'(r_count);
    assign w_ptr_p1 = w_ptr_x + PTR_W'(1);
    assign w_ptr_p2 = w_ptr_x + PTR_W'(2);
    assign w_cnt_m1 = r_count - CNT_W'(1);

    assign o_status.full      = (r_count == CNT_W'(CAP));
    assign o_status.empty     = (r_count == '0);
    assign o_status.plate_top = (w_cnt_x > w_plate_base) && (w_cnt_x <= w_plate_end);
    assign o_status.plate_low = (w_cnt_x > w_plate_end);
    assign o_status.more0     = (w_ptr_p1 < w_cnt_p);
    assign o_status.more1     = (w_ptr_p2 < w_cnt_p);

    always_comb begin
        unique case (i_cmd.rd_sel)
            psp_pkg::RD_TOP:   w_raddr = w_cnt_m1[ADDR_W-1:0];
            psp_pkg::RD_SLOT:  w_raddr = w_slot[ADDR_W-1:0];
            psp_pkg::RD_NEXT1: w_raddr = w_ptr_p1[ADDR_W-1:0];
            psp_pkg::RD_NEXT2: w_raddr = w_ptr_p2[ADDR_W-1:0];
            default:           w_raddr = w_cnt_m1[ADDR_W-1:0];
        endcase
    end

    assign w_we    = i_cmd.push_wr | i_cmd.shift_wr;
    assign w_waddr = i_cmd.push_wr ? r_count[ADDR_W-1:0] : r_ptr;
    assign w_wdata = i_cmd.push_wr ? r_val : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push_wr) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.dec) begin
            r_count <= w_cnt_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val   <= w_in_ext[DATA_W-1:0];
            r_plate <= i_plate_index;
        end
        if (i_cmd.load_ptr) begin
            r_ptr <= w_slot[ADDR_W-1:0];
        end else if (i_cmd.shift_wr) begin
            r_ptr <= w_ptr_p1[ADDR_W-1:0];
        end
        unique case (i_cmd.res_sel)
            psp_pkg::RES_HOLD: ;
            psp_pkg::RES_FAIL: begin
                r_res_value <= '0;
                r_res_ok    <= 1'b0;
            end
            psp_pkg::RES_PUSH: begin
                r_res_value <= '0;
                r_res_ok    <= 1'b1;
            end
            psp_pkg::RES_READ: begin
                r_res_value <= w_rd_ext[psp_pkg::VALUE_W-1:0];
                r_res_ok    <= 1'b1;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out_value <= r_res_value;
            r_out_ok    <= r_res_ok;
            r_out_occ   <= psp_pkg::OCC_W'(r_count);
        end
    end

    assign o_out_value = r_out_value;
    assign o_out_ok    = r_out_ok;
    assign o_occupancy = r_out_occ;

endmodule

>>> rtl/plate_stack_with_pop_at.sv
`timescale 1ns / 1ps

// Bounded stack of NUM_PLATES plates, PLATE_DEPTH entries each, held in one
// single-port-write memory with a registered read and an item count. Push
// stores on top, pop returns the top, pop-at returns the topmost entry of a
// named plate and, for a plate below the top plate, closes the gap by moving
// every entry above it down by one. Each transaction in yields one
// transaction out carrying the value, an ok flag and the occupancy after the
// operation; refused operations return ok 0, value 0. One operation is in
// flight at a time; a new transaction is accepted only after the previous
// result has been loaded for output. The memory read is registered, and the
// shift walks the memory one entry per cycle. A result not yet taken holds
// the block in its final state until the output side takes it.

module plate_stack_with_pop_at #(
    parameter int PLATE_DEPTH = 8,
    parameter int NUM_PLATES  = 16,
    parameter int DATA_W      = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [31:0] push_value, [35:32] plate_index, [39:36] zero
    input  logic [psp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] func
    input  logic [psp_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] out_value, [39:32] occupancy
    output logic [psp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] ok
    output logic [psp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    psp_pkg::t_cmd                  w_cmd;
    psp_pkg::t_status               w_status;
    logic [psp_pkg::VALUE_W-1:0]    w_out_value;
    logic                           w_out_ok;
    logic [psp_pkg::OCC_W-1:0]      w_occ;

    psp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (psp_pkg::t_func'(s_axis_tuser[psp_pkg::FUNC_W-1:0])),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    psp_dp #(
        .PLATE_DEPTH (PLATE_DEPTH),
        .NUM_PLATES  (NUM_PLATES),
        .DATA_W      (DATA_W)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_push_value  (s_axis_tdata[psp_pkg::VALUE_W-1:0]),
        .i_plate_index (s_axis_tdata[psp_pkg::VALUE_W +: psp_pkg::PLATE_W]),
        .o_out_value   (w_out_value),
        .o_out_ok      (w_out_ok),
        .o_occupancy   (w_occ)
    );

    assign m_axis_tdata = {w_occ, w_out_value};
    assign m_axis_tuser = w_out_ok;

endmodule
